// ===== design/mmtd_pkg.sv =====
// Package for the meow-coded Morse text decoder.
// Holds character constants, word-kind codes and the Morse lookup table.
// No dependencies.
package mmtd_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChM     = 8'h6d;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChO     = 8'h6f;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChA     = 8'h61;

  // word in progress
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindMeow = 2'd1;
  localparam logic [1:0] KindRawr = 2'd2;

  localparam int unsigned MaxSymbols = 5;

  // Expected character at position pos of the word of the given kind.
  function automatic logic [7:0] expected_char(input logic [1:0] kind, input logic [1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (kind == KindMeow) begin
      case (pos)
        2'd0:    ch = ChM;
        2'd1:    ch = ChE;
        2'd2:    ch = ChO;
        default: ch = ChW;
      endcase
    end else begin
      case (pos)
        2'd0:    ch = ChR;
        2'd1:    ch = ChA;
        2'd2:    ch = ChW;
        default: ch = ChR;
      endcase
    end
    return ch;
  endfunction

  // Index is a leading one above the symbols (dash = 1, first symbol highest).
  // Zero means no character.
  function automatic logic [7:0] code_lookup(input logic [5:0] idx);
    logic [7:0] ch;
    case (idx)
      6'd2:    ch = "e";
      6'd3:    ch = "t";
      6'd4:    ch = "i";
      6'd5:    ch = "a";
      6'd6:    ch = "n";
      6'd7:    ch = "m";
      6'd8:    ch = "s";
      6'd9:    ch = "u";
      6'd10:   ch = "r";
      6'd11:   ch = "w";
      6'd12:   ch = "d";
      6'd13:   ch = "k";
      6'd14:   ch = "g";
      6'd15:   ch = "o";
      6'd16:   ch = "h";
      6'd17:   ch = "v";
      6'd18:   ch = "f";
      6'd20:   ch = "l";
      6'd22:   ch = "p";
      6'd23:   ch = "j";
      6'd24:   ch = "b";
      6'd25:   ch = "x";
      6'd26:   ch = "c";
      6'd27:   ch = "y";
      6'd28:   ch = "z";
      6'd29:   ch = "q";
      6'd32:   ch = "5";
      6'd33:   ch = "4";
      6'd35:   ch = "3";
      6'd39:   ch = "2";
      6'd47:   ch = "1";
      6'd48:   ch = "6";
      6'd56:   ch = "7";
      6'd60:   ch = "8";
      6'd62:   ch = "9";
      6'd63:   ch = "0";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/meow_morse_text_decoder.sv =====
// Meow-coded Morse text decoder, top level.
// Uses mmtd_pkg for constants and the Morse table.
//
// Usage:
//   Input stream s_axis: one text byte per word in tdata[7:0]; tlast marks the
//   final byte of a message and closes any open token. Spaces split tokens;
//   "meow" is a dot and "rawr" a dash; 1 to 5 of them decode to a letter or
//   digit if the table has the code, "/" to a space, "//" to a slash.
//   Anything else is dropped. Output stream m_axis: one decoded ASCII
//   character per word in tdata[7:0]. A byte yields zero or one output word.
//   An accepted byte sits in the input register and is decoded into the
//   output register once that register is empty or its word is taken.
//   Throughput: one byte per cycle while m_axis_tready_i is high; the decode
//   is a single pass of small logic between the input and output registers.
//   Stall: when the receiver holds tready low with a result pending, the
//   input register still takes one more byte if it is empty; after that
//   s_axis_tready_o drops until the output word is taken.
//   Reset: rst_ni (async, active low) empties both registers and clears the
//   token state; the first byte after reset starts a new token.
module meow_morse_text_decoder
  import mmtd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [7:0] decoded_char
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q;

  // token state
  logic [1:0] kind_q, kind_d;
  logic [1:0] pos_q, pos_d;
  logic [4:0] bits_q, bits_d;
  logic [2:0] count_q, count_d;
  logic [1:0] slash_q, slash_d;
  logic       bad_q, bad_d;
  logic       started_q, started_d;

  logic       advance, process, is_space, closing, ch_ok;
  logic [5:0] table_idx;
  logic [7:0] ch;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign process         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign is_space        = (in_byte_q == ChSpace);
  assign closing         = is_space || in_last_q;

  always_comb begin
    kind_d    = kind_q;
    pos_d     = pos_q;
    bits_d    = bits_q;
    count_d   = count_q;
    slash_d   = slash_q;
    bad_d     = bad_q;
    started_d = started_q;
    ch        = 8'h00;
    table_idx = 6'd0;

    if (!is_space) begin
      started_d = 1'b1;
      if (kind_q != KindNone) begin
        if (in_byte_q == expected_char(kind_q, pos_q)) begin
          pos_d = pos_q + 2'd1;
          if (pos_q == 2'd3) begin
            if (count_q >= 3'(MaxSymbols)) begin
              bad_d = 1'b1;
            end else begin
              bits_d  = {bits_q[3:0], (kind_q == KindRawr)};
              count_d = count_q + 3'd1;
            end
            kind_d = KindNone;
            pos_d  = 2'd0;
          end
        end else begin
          bad_d  = 1'b1;
          kind_d = KindNone;
          pos_d  = 2'd0;
        end
      end else if (in_byte_q == ChM || in_byte_q == ChR) begin
        if (slash_q != 2'd0) begin
          bad_d = 1'b1;
        end
        kind_d = (in_byte_q == ChM) ? KindMeow : KindRawr;
        pos_d  = 2'd1;
      end else if (in_byte_q == ChSlash) begin
        if (count_q != 3'd0) begin
          bad_d = 1'b1;
        end
        if (slash_q != 2'd3) begin
          slash_d = slash_q + 2'd1;
        end
      end else begin
        bad_d = 1'b1;
      end
    end

    if (closing) begin
      table_idx = (6'd1 << count_d) | {1'b0, bits_d};
      if (started_d && !bad_d && kind_d == KindNone) begin
        if (slash_d == 2'd1) begin
          ch = ChSpace;
        end else if (slash_d == 2'd2) begin
          ch = ChSlash;
        end else if (slash_d == 2'd0 && count_d != 3'd0 && count_d <= 3'(MaxSymbols)) begin
          ch = code_lookup(table_idx);
        end
      end
      kind_d    = KindNone;
      pos_d     = 2'd0;
      bits_d    = 5'd0;
      count_d   = 3'd0;
      slash_d   = 2'd0;
      bad_d     = 1'b0;
      started_d = 1'b0;
    end
  end

  assign ch_ok = (ch != 8'h00);

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = process && ch_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KindNone;
      pos_q       <= 2'd0;
      bits_q      <= 5'd0;
      count_q     <= 3'd0;
      slash_q     <= 2'd0;
      bad_q       <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (process) begin
        kind_q    <= kind_d;
        pos_q     <= pos_d;
        bits_q    <= bits_d;
        count_q   <= count_d;
        slash_q   <= slash_d;
        bad_q     <= bad_d;
        started_q <= started_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (process && ch_ok) begin
      out_data_q <= ch;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
